[design/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// shared widths, command and status codes and sequencer states for the
// sparse set membership block
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int ENTITY_W    = 10;
  localparam int SLOT_W      = 10;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 11;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR     = 4'b0001,
    S_IDLE      = 4'b0010,
    S_RD_SPARSE = 4'b0100,
    S_RD_DENSE  = 4'b1000
  } state_t;

endpackage

[design/ssm_spram.sv]
// ----------------------------------------------------------------------------
// ssm_spram
// single-port synchronous ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module ssm_spram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/sparse_set_membership_top.sv]
// ----------------------------------------------------------------------------
// sparse_set_membership_top
// sparse set of entity ids: sparse index ram (entity to slot) plus packed
// dense member ram, with a member count
// ----------------------------------------------------------------------------
// usage:
//   a request (in_command, in_entity_id) is taken on a rising edge with start
//   high and busy low. add appends the entity to the dense list; remove moves
//   the last member into the vacated slot and repoints its index.
//   each request gives exactly one result, shown on the out_ ports for one
//   cycle with out_valid high; the receiver cannot stall it.
// sequencing:
//   out_valid rises in the same cycle that busy drops, so a new request is
//   taken only after the previous one has finished. the steps are the
//   dependent reads: index ram, then dense ram, then write-back of both
//   single-port rams in the same cycle.
// reset:
//   synchronous active-low reset clears the count, then a clearing pass
//   writes zero to both rams, one entry per cycle, over all ENTITY_COUNT
//   entries; busy stays high during the pass.
// ----------------------------------------------------------------------------
module sparse_set_membership_top #(
  parameter int ENTITY_COUNT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [ssm_pkg::ENTITY_W-1:0]       in_entity_id,
  output logic                               out_valid,
  output logic [ssm_pkg::STATUS_W-1:0]       out_status,
  output logic [ssm_pkg::SLOT_W-1:0]         out_slot,
  output logic [ssm_pkg::ENTITY_W-1:0]       out_moved_entity,
  output logic [ssm_pkg::COUNT_OUT_W-1:0]    out_member_count
);

  localparam int AW = $clog2(ENTITY_COUNT);
  localparam int CW = $clog2(ENTITY_COUNT + 1);

  ssm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                   count_r, count_nxt;
  logic [AW-1:0]                   clr_addr_r;
  logic                            cmd_r;
  logic [ssm_pkg::ENTITY_W-1:0]    ent_r;
  logic                            inrange_r;
  logic [ssm_pkg::SLOT_W-1:0]      slot_r;
  logic [ssm_pkg::ENTITY_W-1:0]    last_r;

  logic                            out_valid_r;
  logic [ssm_pkg::STATUS_W-1:0]    out_status_r, status_nxt;
  logic [ssm_pkg::SLOT_W-1:0]      out_slot_r, oslot_nxt;
  logic [ssm_pkg::ENTITY_W-1:0]    out_moved_r, moved_nxt;

  logic                            sp_we, dn_we;
  logic [AW-1:0]                   sp_addr, dn_addr;
  logic [ssm_pkg::SLOT_W-1:0]      sp_wdata, sp_rdata;
  logic [ssm_pkg::ENTITY_W-1:0]    dn_wdata, dn_rdata;

  logic                            accept;
  logic                            member;
  logic                            full;
  logic                            last_inrange;

  assign accept       = start && (state_r == ssm_pkg::S_IDLE);
  assign member       = (32'(slot_r) < 32'(count_r)) && (dn_rdata == ent_r);
  assign full         = 32'(count_r) >= ENTITY_COUNT;
  assign last_inrange = 32'(last_r) < ENTITY_COUNT;

  ssm_spram #(.DEPTH(ENTITY_COUNT), .WIDTH(ssm_pkg::SLOT_W)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .addr  (sp_addr),
    .wdata (sp_wdata),
    .rdata (sp_rdata)
  );

  ssm_spram #(.DEPTH(ENTITY_COUNT), .WIDTH(ssm_pkg::ENTITY_W)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .addr  (dn_addr),
    .wdata (dn_wdata),
    .rdata (dn_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sp_we      = 1'b0;
    dn_we      = 1'b0;
    sp_addr    = AW'(in_entity_id);
    dn_addr    = AW'(count_r - CW'(1));
    sp_wdata   = '0;
    dn_wdata   = '0;
    status_nxt = ssm_pkg::ST_DONE;
    oslot_nxt  = '0;
    moved_nxt  = ent_r;
    unique case (state_r)
      ssm_pkg::S_CLEAR: begin
        sp_we   = 1'b1;
        dn_we   = 1'b1;
        sp_addr = clr_addr_r;
        dn_addr = clr_addr_r;
        if (clr_addr_r == AW'(ENTITY_COUNT - 1)) begin
          state_nxt = ssm_pkg::S_IDLE;
        end
      end
      ssm_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = ssm_pkg::S_RD_SPARSE;
        end
      end
      ssm_pkg::S_RD_SPARSE: begin
        // look up the dense entry at the indexed slot
        dn_addr   = AW'(sp_rdata);
        state_nxt = ssm_pkg::S_RD_DENSE;
      end
      ssm_pkg::S_RD_DENSE: begin
        state_nxt = ssm_pkg::S_IDLE;
        priority if (!inrange_r) begin
          status_nxt = ssm_pkg::ST_ABSENT;
        end else if (cmd_r == ssm_pkg::CMD_ADD) begin
          priority if (member) begin
            status_nxt = ssm_pkg::ST_DUPLICATE;
            oslot_nxt  = slot_r;
          end else if (full) begin
            status_nxt = ssm_pkg::ST_DUPLICATE;
          end else begin
            sp_we     = 1'b1;
            sp_addr   = AW'(ent_r);
            sp_wdata  = ssm_pkg::SLOT_W'(count_r);
            dn_we     = 1'b1;
            dn_addr   = AW'(count_r);
            dn_wdata  = ent_r;
            oslot_nxt = ssm_pkg::SLOT_W'(count_r);
            count_nxt = count_r + CW'(1);
          end
        end else begin
          if (!member) begin
            status_nxt = ssm_pkg::ST_ABSENT;
          end else begin
            // last member fills the vacated slot
            dn_we     = 1'b1;
            dn_addr   = AW'(slot_r);
            dn_wdata  = last_r;
            sp_we     = last_inrange;
            sp_addr   = AW'(last_r);
            sp_wdata  = slot_r;
            oslot_nxt = slot_r;
            moved_nxt = last_r;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ssm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssm_pkg::S_CLEAR;
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == ssm_pkg::S_RD_DENSE);
      if (state_r == ssm_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      ent_r     <= in_entity_id;
      inrange_r <= 32'(in_entity_id) < ENTITY_COUNT;
    end
    if (state_r == ssm_pkg::S_RD_SPARSE) begin
      slot_r <= sp_rdata;
      last_r <= dn_rdata;
    end
    if (state_r == ssm_pkg::S_RD_DENSE) begin
      out_status_r <= status_nxt;
      out_slot_r   <= oslot_nxt;
      out_moved_r  <= moved_nxt;
    end
  end

  assign busy             = (state_r != ssm_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_moved_entity = out_moved_r;
  assign out_member_count = ssm_pkg::COUNT_OUT_W'(count_r);

  a_result_after_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ssm_pkg::S_RD_DENSE))
    else $error("result strobe without a finished lookup");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= ENTITY_COUNT)
    else $error("member count beyond capacity");

  a_rejected_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ssm_pkg::ST_DONE) |-> $stable(count_r))
    else $error("rejected request changed the count");

  a_count_moves_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ssm_pkg::ST_DONE) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("accepted request did not move the count by one");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssm_pkg::S_IDLE) || (state_r == ssm_pkg::S_RD_SPARSE) |-> !sp_we && !dn_we)
    else $error("ram write outside clear or write-back");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the sparse set membership block. Each accepted request runs through
// a predictor of both stores and the member count. Each result pulse is
// compared field by field with the oldest predicted outcome. Stimulus has
// three parts: a directed part, random add/remove traffic biased toward
// current members, and a fill of the whole set followed by traffic starting at
// full occupancy. Requests are sent in bursts with random gaps between them.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [ssm_pkg::STATUS_W-1:0]    status;
  logic [ssm_pkg::SLOT_W-1:0]      slot;
  logic [ssm_pkg::ENTITY_W-1:0]    moved;
  logic [ssm_pkg::COUNT_OUT_W-1:0] members;
} outcome_t;

class membership_scoreboard;
  logic [ssm_pkg::SLOT_W-1:0]   slot_of [1 << ssm_pkg::ENTITY_W];
  logic [ssm_pkg::ENTITY_W-1:0] dense   [1 << ssm_pkg::ENTITY_W];
  int unsigned                  members;
  outcome_t                     pending [$];
  int                           errors;

  function new();
    for (int i = 0; i < (1 << ssm_pkg::ENTITY_W); i++) begin
      slot_of[i] = '0;
      dense[i]   = '0;
    end
    members = 0;
    errors  = 0;
  endfunction

  function bit holds(logic [ssm_pkg::ENTITY_W-1:0] id);
    int unsigned s;
    s = 32'(slot_of[id]);
    return (s < members) && (dense[s] == id);
  endfunction

  function void note_request(logic cmd, logic [ssm_pkg::ENTITY_W-1:0] id);
    outcome_t    o;
    int unsigned s;
    logic [ssm_pkg::ENTITY_W-1:0] last;
    bit          member;
    s        = 32'(slot_of[id]);
    member   = holds(id);
    o.status = ssm_pkg::ST_DONE;
    o.slot   = '0;
    o.moved  = id;
    if (cmd == ssm_pkg::CMD_ADD) begin
      if (member) begin
        o.status = ssm_pkg::ST_DUPLICATE;
        o.slot   = s[ssm_pkg::SLOT_W-1:0];
      end else if (members >= (1 << ssm_pkg::ENTITY_W)) begin
        o.status = ssm_pkg::ST_DUPLICATE;
      end else begin
        o.slot           = members[ssm_pkg::SLOT_W-1:0];
        slot_of[id]      = members[ssm_pkg::SLOT_W-1:0];
        dense[members]   = id;
        members          = members + 1;
      end
    end else begin
      if (!member) begin
        o.status = ssm_pkg::ST_ABSENT;
      end else begin
        last          = dense[members - 1];
        dense[s]      = last;
        slot_of[last] = s[ssm_pkg::SLOT_W-1:0];
        members       = members - 1;
        o.slot        = s[ssm_pkg::SLOT_W-1:0];
        o.moved       = last;
      end
    end
    o.members = members[ssm_pkg::COUNT_OUT_W-1:0];
    pending.push_back(o);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task check_result(logic [ssm_pkg::STATUS_W-1:0] status,
                    logic [ssm_pkg::SLOT_W-1:0] slot,
                    logic [ssm_pkg::ENTITY_W-1:0] moved,
                    logic [ssm_pkg::COUNT_OUT_W-1:0] count);
    outcome_t o;
    if (pending.size() == 0) begin
      report("unexpected result, status", int'(status), -1);
    end else begin
      o = pending.pop_front();
      if (status !== o.status) report("status", int'(status), int'(o.status));
      if (slot !== o.slot) report("slot", int'(slot), int'(o.slot));
      if (moved !== o.moved) report("moved_entity", int'(moved), int'(o.moved));
      if (count !== o.members) report("member_count", int'(count), int'(o.members));
    end
  endtask
endclass

module tb;
  localparam int SET_SIZE    = 1 << ssm_pkg::ENTITY_W;
  localparam int CYCLE_LIMIT = 200000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               in_command = 1'b0;
  logic [ssm_pkg::ENTITY_W-1:0]       in_entity_id = '0;
  logic                               out_valid;
  logic [ssm_pkg::STATUS_W-1:0]       out_status;
  logic [ssm_pkg::SLOT_W-1:0]         out_slot;
  logic [ssm_pkg::ENTITY_W-1:0]       out_moved_entity;
  logic [ssm_pkg::COUNT_OUT_W-1:0]    out_member_count;

  membership_scoreboard sb;
  int                   burst_left = 0;
  int                   cycles = 0;

  sparse_set_membership_top #(
    .ENTITY_COUNT(SET_SIZE)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entity_id     (in_entity_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_moved_entity (out_moved_entity),
    .out_member_count (out_member_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_status, out_slot, out_moved_entity, out_member_count);
    end
  end

  task automatic idle_gap();
    start        <= 1'b0;
    in_command   <= 1'($urandom_range(0, 1));
    in_entity_id <= ssm_pkg::ENTITY_W'($urandom_range(0, SET_SIZE - 1));
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  task automatic issue(input logic cmd, input logic [ssm_pkg::ENTITY_W-1:0] id);
    if (burst_left == 0) begin
      idle_gap();
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    start        <= 1'b1;
    in_command   <= cmd;
    in_entity_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, id);
  endtask

  function automatic logic [ssm_pkg::ENTITY_W-1:0] pick_id();
    case ($urandom_range(0, 3))
      0:       return ssm_pkg::ENTITY_W'($urandom_range(0, 15));
      1:       return ssm_pkg::ENTITY_W'($urandom_range(SET_SIZE - 16, SET_SIZE - 1));
      default: return ssm_pkg::ENTITY_W'($urandom_range(0, SET_SIZE - 1));
    endcase
  endfunction

  task automatic run_mixed(input int n, input int add_weight);
    logic                         cmd;
    logic [ssm_pkg::ENTITY_W-1:0] id;
    repeat (n) begin
      cmd = ($urandom_range(0, 9) < add_weight) ? ssm_pkg::CMD_ADD : ssm_pkg::CMD_REMOVE;
      if (sb.members != 0 &&
          $urandom_range(0, 9) < ((cmd == ssm_pkg::CMD_REMOVE) ? 7 : 3)) begin
        id = sb.dense[$urandom_range(0, sb.members - 1)];
      end else begin
        id = pick_id();
      end
      issue(cmd, id);
    end
  endtask

  task automatic run_fill();
    int order [SET_SIZE];
    int j;
    int t;
    for (int i = 0; i < SET_SIZE; i++) order[i] = i;
    for (int i = SET_SIZE - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < SET_SIZE; i++) begin
      if (!sb.holds(ssm_pkg::ENTITY_W'(order[i]))) begin
        issue(ssm_pkg::CMD_ADD, ssm_pkg::ENTITY_W'(order[i]));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    issue(ssm_pkg::CMD_REMOVE, 10'd0);
    issue(ssm_pkg::CMD_ADD,    10'd0);
    issue(ssm_pkg::CMD_ADD,    10'd0);
    issue(ssm_pkg::CMD_ADD,    10'd1023);
    issue(ssm_pkg::CMD_ADD,    10'd512);
    issue(ssm_pkg::CMD_ADD,    10'h155);
    issue(ssm_pkg::CMD_ADD,    10'h2aa);
    issue(ssm_pkg::CMD_REMOVE, 10'd1023);
    issue(ssm_pkg::CMD_REMOVE, 10'h155);
    issue(ssm_pkg::CMD_REMOVE, 10'h155);
    issue(ssm_pkg::CMD_REMOVE, 10'd0);
    issue(ssm_pkg::CMD_ADD,    10'd1023);
    issue(ssm_pkg::CMD_ADD,    10'd1023);
    issue(ssm_pkg::CMD_ADD,    10'd512);
    issue(ssm_pkg::CMD_REMOVE, 10'd1023);
    issue(ssm_pkg::CMD_REMOVE, 10'h2aa);
    issue(ssm_pkg::CMD_REMOVE, 10'd512);
    issue(ssm_pkg::CMD_REMOVE, 10'd512);
    issue(ssm_pkg::CMD_REMOVE, 10'd0);
    issue(ssm_pkg::CMD_ADD,    10'd5);
    issue(ssm_pkg::CMD_REMOVE, 10'd5);

    // random traffic, growing, then shrinking, then growing again
    run_mixed(150, 7);
    run_mixed(100, 3);
    run_mixed(50, 6);

    // fill the set completely, then work starting from full occupancy
    run_fill();
    run_mixed(30, 7);
    run_mixed(50, 3);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
